@@ sv/iir4_pkg.sv @@
// Shared types, codes and the step schedule of the fourth-order IIR filter.
// Used by the register bank, the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package iir4_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 28;
    localparam int STATE_W    = 64;
    localparam int WIDE_W     = 96;
    localparam int MUL_W      = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Sequencer length: one step for each entry of the schedule below.
    localparam int NUM_STEPS = 15;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0_B1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2_B3    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B4       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1_A2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A3_A4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_D0_D1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_D2_D3 = 3'd6;

    // Coefficient select codes for the shared multiplier.
    localparam logic [3:0] COEF_B0 = 4'd0;
    localparam logic [3:0] COEF_B1 = 4'd1;
    localparam logic [3:0] COEF_B2 = 4'd2;
    localparam logic [3:0] COEF_B3 = 4'd3;
    localparam logic [3:0] COEF_B4 = 4'd4;
    localparam logic [3:0] COEF_A1 = 4'd5;
    localparam logic [3:0] COEF_A2 = 4'd6;
    localparam logic [3:0] COEF_A3 = 4'd7;
    localparam logic [3:0] COEF_A4 = 4'd8;

    // Second multiplier operand: the sample, or the low or high half of y.
    localparam logic [1:0] OPND_X  = 2'd0;
    localparam logic [1:0] OPND_YL = 2'd1;
    localparam logic [1:0] OPND_YH = 2'd2;

    // Addend of the feed-forward partial sum.
    localparam logic [1:0] SRC_D1   = 2'd0;
    localparam logic [1:0] SRC_D2   = 2'd1;
    localparam logic [1:0] SRC_D3   = 2'd2;
    localparam logic [1:0] SRC_ZERO = 2'd3;

    // Delay element written by a finish operation.
    localparam logic [1:0] DST_D0 = 2'd0;
    localparam logic [1:0] DST_D1 = 2'd1;
    localparam logic [1:0] DST_D2 = 2'd2;
    localparam logic [1:0] DST_D3 = 2'd3;

    // Command word from the controller to the datapath for one step.
    typedef struct packed {
        logic [3:0] coef_sel;
        logic [1:0] opnd_sel;
        logic       acc_y;
        logic       acc_s;
        logic [1:0] s_src;
        logic       acc_lo;
        logic       acc_hi;
        logic       fin;
        logic [1:0] fin_dst;
        logic       last;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

    // Contents of the configuration registers.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] b0_b1;
        logic [CFG_DATA_W-1:0] b2_b3;
        logic [COEF_W-1:0]     b4;
        logic [CFG_DATA_W-1:0] a1_a2;
        logic [CFG_DATA_W-1:0] a3_a4;
        logic [CFG_DATA_W-1:0] init_d0_d1;
        logic [CFG_DATA_W-1:0] init_d2_d3;
    } cfg_t;

    // Step schedule. Steps 0 to 12 each start one multiply, and steps 1 to 13 each retire
    // the product started in the step before it. A coefficient-by-y product takes two
    // passes (low then high half of y) that meet in the wide accumulator.
    function automatic cmd_t step_cmd(input logic [STEP_W-1:0] step);
        cmd_t c;
        c = '0;
        unique case (step)
            4'd0: begin
                c.coef_sel = COEF_B0; c.opnd_sel = OPND_X;
            end
            4'd1: begin
                c.acc_y = 1'b1;
                c.coef_sel = COEF_B1; c.opnd_sel = OPND_X;
            end
            4'd2: begin
                c.acc_s = 1'b1; c.s_src = SRC_D1;
                c.coef_sel = COEF_A1; c.opnd_sel = OPND_YL;
            end
            4'd3: begin
                c.acc_lo = 1'b1;
                c.coef_sel = COEF_A1; c.opnd_sel = OPND_YH;
            end
            4'd4: begin
                c.acc_hi = 1'b1;
                c.coef_sel = COEF_B2; c.opnd_sel = OPND_X;
            end
            4'd5: begin
                c.fin = 1'b1; c.fin_dst = DST_D0;
                c.acc_s = 1'b1; c.s_src = SRC_D2;
                c.coef_sel = COEF_A2; c.opnd_sel = OPND_YL;
            end
            4'd6: begin
                c.acc_lo = 1'b1;
                c.coef_sel = COEF_A2; c.opnd_sel = OPND_YH;
            end
            4'd7: begin
                c.acc_hi = 1'b1;
                c.coef_sel = COEF_B3; c.opnd_sel = OPND_X;
            end
            4'd8: begin
                c.fin = 1'b1; c.fin_dst = DST_D1;
                c.acc_s = 1'b1; c.s_src = SRC_D3;
                c.coef_sel = COEF_A3; c.opnd_sel = OPND_YL;
            end
            4'd9: begin
                c.acc_lo = 1'b1;
                c.coef_sel = COEF_A3; c.opnd_sel = OPND_YH;
            end
            4'd10: begin
                c.acc_hi = 1'b1;
                c.coef_sel = COEF_B4; c.opnd_sel = OPND_X;
            end
            4'd11: begin
                c.fin = 1'b1; c.fin_dst = DST_D2;
                c.acc_s = 1'b1; c.s_src = SRC_ZERO;
                c.coef_sel = COEF_A4; c.opnd_sel = OPND_YL;
            end
            4'd12: begin
                c.acc_lo = 1'b1;
                c.coef_sel = COEF_A4; c.opnd_sel = OPND_YH;
            end
            4'd13: begin
                c.acc_hi = 1'b1;
            end
            4'd14: begin
                c.fin = 1'b1; c.fin_dst = DST_D3;
                c.last = 1'b1;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/iir_filter_order4.sv @@
// Top level of the fourth-order IIR filter (transposed direct form II).
// Depends on iir4_pkg, iir4_cfg_regs, iir4_ctrl and iir4_dp.
//
// Each input word (a signed 24-bit sample and a restart bit) is captured on
// acceptance and then runs through fifteen sequencer steps before the next
// ready; the steps drive thirteen passes through one shared 33x33 multiplier
// (five feed-forward products and four feedback products of two passes each)
// plus one final step that writes the last delay element and the output
// register. Coefficients are signed Q4.28; the delays hold Q36.28 values and
// saturate at 64 bits. The result is rounded to nearest,
// ties up, clamped to 24 bits, and flagged as clipped if any sum or the
// output saturated. A finished result waits in its own register, so the
// next sample is taken while it waits; only the final step stalls on a full
// output. Configuration writes are taken every cycle and must be made only
// while the filter is idle; index 7 is ignored.
`default_nettype none

module iir_filter_order4 (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [iir4_pkg::SAMPLE_W-1:0]   s_sample,
    input  wire logic                                   s_restart,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [iir4_pkg::SAMPLE_W-1:0]        m_filtered,
    output logic                                        m_clipped,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [iir4_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [iir4_pkg::CFG_DATA_W-1:0]        cfg_data
);

    iir4_pkg::cfg_t    cfg;
    iir4_pkg::cmd_t    cmd;
    iir4_pkg::status_t status;
    logic              start;
    logic              step_en;

    // Configuration registers.
    iir4_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    // Step sequencer.
    iir4_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .start   (start),
        .step_en (step_en),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    iir4_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_sample   (s_sample),
        .s_restart  (s_restart),
        .start      (start),
        .step_en    (step_en),
        .cmd        (cmd),
        .status     (status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .m_clipped  (m_clipped)
    );

endmodule

`default_nettype wire

@@ sv/iir4_cfg_regs.sv @@
// Configuration register bank of the fourth-order IIR filter.
// Depends on iir4_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module iir4_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [iir4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [iir4_pkg::CFG_DATA_W-1:0]     cfg_data,
    output iir4_pkg::cfg_t                           regs
);

    iir4_pkg::cfg_t regs_reg;
    iir4_pkg::cfg_t regs_next;

    // Writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    // Register write decode.
    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                iir4_pkg::REG_COEF_B0_B1:    regs_next.b0_b1      = cfg_data;
                iir4_pkg::REG_COEF_B2_B3:    regs_next.b2_b3      = cfg_data;
                iir4_pkg::REG_COEF_B4:
                    regs_next.b4 = cfg_data[iir4_pkg::COEF_W-1:0];
                iir4_pkg::REG_COEF_A1_A2:    regs_next.a1_a2      = cfg_data;
                iir4_pkg::REG_COEF_A3_A4:    regs_next.a3_a4      = cfg_data;
                iir4_pkg::REG_INITIAL_D0_D1: regs_next.init_d0_d1 = cfg_data;
                iir4_pkg::REG_INITIAL_D2_D3: regs_next.init_d2_d3 = cfg_data;
                default:                     regs_next            = regs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/iir4_ctrl.sv @@
// Sequencer of the fourth-order IIR filter: accepts a word and steps the
// datapath through the schedule. Depends on iir4_pkg for cmd_t and step_cmd.
`default_nettype none

module iir4_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire iir4_pkg::status_t       status,
    output logic                         start,
    output logic                         step_en,
    output iir4_pkg::cmd_t               cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [iir4_pkg::STEP_W-1:0]   step_reg;
    logic [iir4_pkg::STEP_W-1:0]   step_next;

    // A new word is taken whenever no sample is in progress.
    assign s_ready = (state_reg == ST_IDLE);
    assign start   = s_valid && s_ready;
    assign cmd     = iir4_pkg::step_cmd(step_reg);

    // The final step holds until the output register can take the result.
    assign step_en = (state_reg == ST_RUN) && (!cmd.last || status.out_free);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // A sample always begins at the first step of the schedule.
    a_start_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("sequencer did not begin at step zero");

    // The step counter never runs past the schedule.
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg < iir4_pkg::STEP_W'(iir4_pkg::NUM_STEPS)))
        else $error("step counter ran past the schedule");

    // A held step keeps its place.
    a_hold_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RUN) && !step_en) |=>
            ((state_reg == ST_RUN) && $stable(step_reg)))
        else $error("held step did not keep its place");

endmodule

`default_nettype wire

@@ sv/iir4_dp.sv @@
// Datapath of the fourth-order IIR filter: shared multiplier, saturating
// adders, wide accumulator, delay elements and the output register.
// Depends on iir4_pkg for widths, codes, cmd_t, status_t and cfg_t.
`default_nettype none

module iir4_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire iir4_pkg::cfg_t                         cfg,
    input  wire logic signed [iir4_pkg::SAMPLE_W-1:0]   s_sample,
    input  wire logic                                   s_restart,
    input  wire logic                                   start,
    input  wire logic                                   step_en,
    input  wire iir4_pkg::cmd_t                         cmd,
    output iir4_pkg::status_t                           status,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [iir4_pkg::SAMPLE_W-1:0]        m_filtered,
    output logic                                        m_clipped
);

    localparam int SW = iir4_pkg::STATE_W;
    localparam int CW = iir4_pkg::COEF_W;
    localparam int FW = iir4_pkg::FRAC_W;
    localparam int WW = iir4_pkg::WIDE_W;
    localparam int MW = iir4_pkg::MUL_W;
    localparam int XW = iir4_pkg::SAMPLE_W;
    // Integer part of y plus one bit of headroom for the rounding increment.
    localparam int QW = SW - FW + 1;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [QW-1:0] Q_MAX = QW'(signed'(XW'({1'b0, {(XW-1){1'b1}}})));
    localparam logic signed [QW-1:0] Q_MIN = QW'(signed'(XW'({1'b1, {(XW-1){1'b0}}})));

    // Saturating add; the top bit of the result flags saturation.
    function automatic logic [SW:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0]   sum;
        logic          ovf;
        logic [SW-1:0] res;
        sum = {a[SW-1], a} + {b[SW-1], b};
        ovf = sum[SW] ^ sum[SW-1];
        res = ovf ? (sum[SW] ? S_MIN : S_MAX) : sum[SW-1:0];
        return {ovf, res};
    endfunction

    // Saturating subtract; the top bit of the result flags saturation.
    function automatic logic [SW:0] sat_sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0]   dif;
        logic          ovf;
        logic [SW-1:0] res;
        dif = {a[SW-1], a} - {b[SW-1], b};
        ovf = dif[SW] ^ dif[SW-1];
        res = ovf ? (dif[SW] ? S_MIN : S_MAX) : dif[SW-1:0];
        return {ovf, res};
    endfunction

    logic [XW-1:0]  x_reg;
    logic [SW-1:0]  d_reg [4];
    logic [SW-1:0]  y_reg;
    logic [SW-1:0]  s_reg;
    logic [WW-1:0]  acc_reg;
    logic [SW-1:0]  prod_reg;
    logic           sat_reg;
    logic           out_valid_reg;
    logic [XW-1:0]  filtered_reg;
    logic           clipped_reg;

    logic [CW-1:0]         coef_op;
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [2*MW-1:0] mul_full;
    logic [SW-1:0]         s_addend;
    logic [SW:0]           y_sum;
    logic [SW:0]           s_sum;
    logic [SW:0]           fin_res;
    logic                  m_fits;
    logic [SW-1:0]         m_val;
    logic                  step_sat;
    logic signed [QW-1:0]  q_val;
    logic                  q_hi;
    logic                  q_lo;
    logic [XW-1:0]         q_sat;
    logic                  out_load;

    // Coefficient select; the first value of a pair sits in the upper half.
    always_comb begin
        unique case (cmd.coef_sel)
            iir4_pkg::COEF_B0: coef_op = cfg.b0_b1[2*CW-1:CW];
            iir4_pkg::COEF_B1: coef_op = cfg.b0_b1[CW-1:0];
            iir4_pkg::COEF_B2: coef_op = cfg.b2_b3[2*CW-1:CW];
            iir4_pkg::COEF_B3: coef_op = cfg.b2_b3[CW-1:0];
            iir4_pkg::COEF_B4: coef_op = cfg.b4;
            iir4_pkg::COEF_A1: coef_op = cfg.a1_a2[2*CW-1:CW];
            iir4_pkg::COEF_A2: coef_op = cfg.a1_a2[CW-1:0];
            iir4_pkg::COEF_A3: coef_op = cfg.a3_a4[2*CW-1:CW];
            iir4_pkg::COEF_A4: coef_op = cfg.a3_a4[CW-1:0];
            default:           coef_op = '0;
        endcase
    end

    // Second operand: the sample, the unsigned low half or the signed high half of y.
    always_comb begin
        unique case (cmd.opnd_sel)
            iir4_pkg::OPND_X:  mul_b = signed'({{(MW-XW){x_reg[XW-1]}}, x_reg});
            iir4_pkg::OPND_YL: mul_b = signed'({1'b0, y_reg[CW-1:0]});
            iir4_pkg::OPND_YH: mul_b = signed'({y_reg[SW-1], y_reg[SW-1:CW]});
            default:           mul_b = '0;
        endcase
    end

    // Shared signed multiplier; every product used here fits in 64 bits.
    assign mul_a    = signed'({coef_op[CW-1], coef_op});
    assign mul_full = mul_a * mul_b;

    // Addend of the feed-forward partial sum.
    always_comb begin
        unique case (cmd.s_src)
            iir4_pkg::SRC_D1:   s_addend = d_reg[1];
            iir4_pkg::SRC_D2:   s_addend = d_reg[2];
            iir4_pkg::SRC_D3:   s_addend = d_reg[3];
            iir4_pkg::SRC_ZERO: s_addend = '0;
        endcase
    end

    assign y_sum = sat_add(prod_reg, d_reg[0]);
    assign s_sum = sat_add(prod_reg, s_addend);

    // Feedback product floored to 28 fractional bits, then saturated to 64 bits.
    assign m_fits  = (&acc_reg[WW-1:SW+FW-1]) || !(|acc_reg[WW-1:SW+FW-1]);
    assign m_val   = m_fits ? acc_reg[SW+FW-1:FW] : (acc_reg[WW-1] ? S_MIN : S_MAX);
    assign fin_res = sat_sub(s_reg, m_val);

    // Saturation raised by the operations of this step.
    assign step_sat = (cmd.acc_y && y_sum[SW]) || (cmd.acc_s && s_sum[SW]) ||
                      (cmd.fin && (!m_fits || fin_res[SW]));

    // Round y to the nearest integer with ties up, then clamp to 24 bits.
    assign q_val = signed'({y_reg[SW-1], y_reg[SW-1:FW]}) +
                   signed'({{(QW-1){1'b0}}, y_reg[FW-1]});
    assign q_hi  = q_val > Q_MAX;
    assign q_lo  = q_val < Q_MIN;
    assign q_sat = q_hi ? Q_MAX[XW-1:0] : (q_lo ? Q_MIN[XW-1:0] : q_val[XW-1:0]);

    assign out_load        = step_en && cmd.last;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid    = out_valid_reg;
    assign m_filtered = signed'(filtered_reg);
    assign m_clipped  = clipped_reg;

    // Sample capture and product register.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= s_sample;
        end
        prod_reg <= mul_full[SW-1:0];
    end

    // Partial sums and the wide accumulator.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            if (cmd.acc_y) begin
                y_reg <= y_sum[SW-1:0];
            end
            if (cmd.acc_s) begin
                s_reg <= s_sum[SW-1:0];
            end
            if (cmd.acc_lo) begin
                acc_reg <= {{(WW-SW){prod_reg[SW-1]}}, prod_reg};
            end else if (cmd.acc_hi) begin
                acc_reg <= acc_reg + {prod_reg, {(WW-SW){1'b0}}};
            end
        end
    end

    // Delay elements: cleared by reset, loaded on restart, written by finishes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                d_reg[i] <= '0;
            end
        end else if (start && s_restart) begin
            d_reg[0] <= {{(SW-CW){cfg.init_d0_d1[2*CW-1]}}, cfg.init_d0_d1[2*CW-1:CW]};
            d_reg[1] <= {{(SW-CW){cfg.init_d0_d1[CW-1]}}, cfg.init_d0_d1[CW-1:0]};
            d_reg[2] <= {{(SW-CW){cfg.init_d2_d3[2*CW-1]}}, cfg.init_d2_d3[2*CW-1:CW]};
            d_reg[3] <= {{(SW-CW){cfg.init_d2_d3[CW-1]}}, cfg.init_d2_d3[CW-1:0]};
        end else if (step_en && cmd.fin) begin
            d_reg[cmd.fin_dst] <= fin_res[SW-1:0];
        end
    end

    // Sticky clip flag for the sample in progress.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (start) begin
            sat_reg <= 1'b0;
        end else if (step_en) begin
            sat_reg <= sat_reg || step_sat;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            filtered_reg <= q_sat;
            clipped_reg  <= sat_reg || step_sat || q_hi || q_lo;
        end
    end

    // The output register is loaded only when it is empty or being emptied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(filtered_reg)))
        else $error("pending result was overwritten");

    // A finished feedback product never leaves the accumulator mid-update.
    a_fin_after_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && cmd.fin) |-> !(cmd.acc_lo || cmd.acc_hi))
        else $error("finish overlaps an accumulator update");

    // A new sample is never captured while a result is being loaded.
    a_start_vs_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(start && out_load))
        else $error("capture and result load in the same cycle");

endmodule

`default_nettype wire

@@ verif/tb_iir_filter_order4.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fourth-order IIR filter top level iir_filter_order4.
// Depends on iir4_pkg and the filter RTL; a bit-exact filter predictor checks every output word.

module tb_iir_filter_order4;
    import iir4_pkg::*;

    localparam int NUM_REGS        = 7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RAND_PHASES     = 10;
    localparam int WORDS_PER_PHASE = 110;
    localparam int LONG_HOLD       = 400;
    localparam int IDLE_LIMIT      = 5000;
    localparam int TAIL_CYCLES     = 40;

    // Q4.28 constants and spans for the random coefficient sets.
    localparam logic [31:0] Q_ONE   = 32'h1000_0000;
    localparam logic [31:0] Q_HALF  = 32'h0800_0000;
    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam int          ONE_INT = 268435456;
    localparam int          A2_SPAN = 187904819;
    localparam int          B_SPAN  = 67108864;
    localparam int          A34_SPAN = 2097152;
    localparam int          INIT_SPAN = 536870912;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh80_0000;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE } rx_mode_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       clipped;
    } out_word_t;

    // Block ports.
    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       s_restart = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_filtered;
    logic                       m_clipped;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // Stimulus and prediction state.
    in_word_t          sample_q[$];
    out_word_t         predicted_q[$];
    logic [CFG_DATA_W-1:0] plan [NUM_REGS];
    logic [CFG_DATA_W-1:0] shadow [NUM_REGS] = '{default: '0};
    logic signed [STATE_W-1:0] dly [4] = '{default: '0};
    logic              sat_seen;

    rx_mode_t rx_mode = RX_ALWAYS;
    logic     gaps_on = 1'b0;
    logic     hold_req = 1'b0;
    logic     s_took = 1'b0;
    int       hold_left = 0;
    int       pat_cnt = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    int       idle_cycles = 0;
    int       words_total = 0;
    int       words_taken = 0;
    int       results_seen = 0;
    int       clips_seen = 0;
    int       restarts_seen = 0;
    int       settings_loaded = 0;
    int       fail_cnt = 0;

    iir_filter_order4 i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_restart  (s_restart),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .m_clipped  (m_clipped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp a wide intermediate to the signed 64-bit delay range.
    function automatic logic signed [STATE_W-1:0] sat64(input logic signed [129:0] v);
        logic signed [129:0] top;
        logic signed [129:0] bot;
        top = $signed({67'd0, {63{1'b1}}});
        bot = -top - 130'sd1;
        if (v > top) begin
            sat_seen = 1'b1;
            return top[STATE_W-1:0];
        end
        if (v < bot) begin
            sat_seen = 1'b1;
            return bot[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // Coefficient times output, floored to 28 fractional bits and saturated.
    function automatic logic signed [STATE_W-1:0] fb_product(input logic signed [31:0] c,
                                                             input logic signed [63:0] y);
        logic signed [129:0] cw;
        logic signed [129:0] yw;
        logic signed [129:0] p;
        cw = c;
        yw = y;
        p = cw * yw;
        return sat64(p >>> FRAC_W);
    endfunction

    // One filter step on the predictor's own delay line.
    function automatic out_word_t filter_step(input logic signed [SAMPLE_W-1:0] x,
                                              input logic restart);
        logic signed [129:0] xw;
        logic signed [129:0] bw;
        logic signed [129:0] acc;
        logic signed [129:0] q;
        logic signed [31:0]  b [5];
        logic signed [31:0]  a [1:4];
        logic signed [31:0]  init [4];
        logic signed [63:0]  y;
        logic signed [63:0]  s;
        out_word_t           r;
        int                  k;
        sat_seen = 1'b0;
        xw = x;
        b[0] = shadow[REG_COEF_B0_B1][63:32];
        b[1] = shadow[REG_COEF_B0_B1][31:0];
        b[2] = shadow[REG_COEF_B2_B3][63:32];
        b[3] = shadow[REG_COEF_B2_B3][31:0];
        b[4] = shadow[REG_COEF_B4][31:0];
        a[1] = shadow[REG_COEF_A1_A2][63:32];
        a[2] = shadow[REG_COEF_A1_A2][31:0];
        a[3] = shadow[REG_COEF_A3_A4][63:32];
        a[4] = shadow[REG_COEF_A3_A4][31:0];

        // Restart loads sign-extended initial values before this sample.
        if (restart) begin
            init[0] = shadow[REG_INITIAL_D0_D1][63:32];
            init[1] = shadow[REG_INITIAL_D0_D1][31:0];
            init[2] = shadow[REG_INITIAL_D2_D3][63:32];
            init[3] = shadow[REG_INITIAL_D2_D3][31:0];
            for (k = 0; k < 4; k++) dly[k] = init[k];
        end

        bw = b[0];
        acc = bw * xw;
        acc = acc + dly[0];
        y = sat64(acc);

        // Transposed update: each delay takes the next one plus its products.
        for (k = 0; k < 3; k++) begin
            bw = b[k+1];
            acc = bw * xw;
            acc = acc + dly[k+1];
            s = sat64(acc);
            acc = s;
            acc = acc - fb_product(a[k+1], y);
            dly[k] = sat64(acc);
        end
        bw = b[4];
        acc = bw * xw;
        acc = acc - fb_product(a[4], y);
        dly[3] = sat64(acc);

        // Round to nearest with ties up, then clamp to 24 bits.
        acc = y;
        q = (acc + 130'sd134217728) >>> FRAC_W;
        if (q > 130'sd8388607) begin
            r.filtered = S_MAX;
            sat_seen = 1'b1;
        end else if (q < -130'sd8388608) begin
            r.filtered = S_MIN;
            sat_seen = 1'b1;
        end else begin
            r.filtered = q[SAMPLE_W-1:0];
        end
        r.clipped = sat_seen;
        return r;
    endfunction

    // Capture handshakes at the rising edge: register shadow, predictions and checks.
    always @(posedge aclk) begin : monitor
        out_word_t want;
        s_took = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
                shadow[cfg_index] = cfg_data;
            if (s_took) begin
                predicted_q = {predicted_q, filter_step(s_sample, s_restart)};
                words_taken++;
                if (s_restart) restarts_seen++;
            end
            if (m_valid && m_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("filtered word %0d arrived with nothing predicted", m_filtered);
                    fail_cnt++;
                end else begin
                    want = predicted_q.pop_front();
                    results_seen++;
                    if (want.clipped) clips_seen++;
                    if (m_filtered !== want.filtered) begin
                        $error("filtered: expected %0d, got %0d", want.filtered, m_filtered);
                        fail_cnt++;
                    end
                    if (m_clipped !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, m_clipped);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no word moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Sample driver: bursts of words from the pending queue, with random gaps while gaps_on is set.
    always @(negedge aclk) begin : driver
        in_word_t w;
        logic     up;
        if (!(s_valid && !s_took)) begin
            up = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (aresetn && sample_q.size() > 0) begin
                w = sample_q.pop_front();
                s_sample  <= w.sample;
                s_restart <= w.restart;
                up = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left = gaps_on ? $urandom_range(30, 1) : 0;
                end
            end
            s_valid <= up;
        end
    end

    // Result receiver: a stall pattern per phase, plus a long hold-off on request.
    always @(negedge aclk) begin : receiver
        logic rdy;
        pat_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  rdy = 1'b1;
                RX_RANDOM:  rdy = $urandom_range(1);
                RX_PATTERN: rdy = (pat_cnt % 11) < 4;
                default:    rdy = ($urandom_range(7) == 0);
            endcase
        end
        m_ready <= rdy;
    end

    // Wait until every queued word was taken and every prediction was matched.
    task automatic wait_drained();
        do @(negedge aclk);
        while (words_taken != words_total || predicted_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write the whole register plan, then poke the unused index with junk.
    task automatic load_plan();
        int i;
        for (i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), plan[i]);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic push_word(input logic signed [SAMPLE_W-1:0] x, input logic restart);
        in_word_t w;
        w.sample = x;
        w.restart = restart;
        sample_q = {sample_q, w};
        words_total++;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic queue_words(input int n, input int restart_pct);
        int i;
        for (i = 0; i < n; i++) push_word(rand_sample(), $urandom_range(99) < restart_pct);
    endtask

    function automatic logic [31:0] rand_coef(input int span);
        return 32'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [31:0] corner_half();
        case ($urandom_range(5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'h0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Mostly stable set: second-order feedback inside its stability triangle.
    task automatic plan_stable();
        int a1;
        int a2;
        int lim;
        a2 = int'($urandom_range(2 * A2_SPAN)) - A2_SPAN;
        lim = (ONE_INT + a2) / 20 * 19;
        a1 = int'($urandom_range(2 * lim)) - lim;
        plan[REG_COEF_B0_B1]    = {rand_coef(B_SPAN), rand_coef(B_SPAN)};
        plan[REG_COEF_B2_B3]    = {rand_coef(B_SPAN), rand_coef(B_SPAN)};
        plan[REG_COEF_B4]       = {$urandom, rand_coef(B_SPAN)};
        plan[REG_COEF_A1_A2]    = {32'(a1), 32'(a2)};
        plan[REG_COEF_A3_A4]    = {rand_coef(A34_SPAN), rand_coef(A34_SPAN)};
        plan[REG_INITIAL_D0_D1] = {rand_coef(INIT_SPAN), rand_coef(INIT_SPAN)};
        plan[REG_INITIAL_D2_D3] = {rand_coef(INIT_SPAN), rand_coef(INIT_SPAN)};
    endtask

    task automatic plan_fill(input logic [31:0] v);
        int i;
        for (i = 0; i < NUM_REGS; i++) plan[i] = {v, v};
    endtask

    initial begin : stimulus
        int p;
        int i;
        int pct;
        logic hold_phase;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset state: all coefficients zero, so every output is zero.
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        push_word(S_MAX, 1'b1);
        push_word(S_MIN, 1'b0);
        wait_drained();

        // Unity pass-through, field extremes, then initial delays that exercise
        // round-half-up on both signs and output clamping at both ends.
        plan_fill(32'h0);
        plan[REG_COEF_B0_B1]    = {Q_ONE, 32'h0};
        plan[REG_COEF_B4]       = {$urandom, 32'h0};
        plan[REG_INITIAL_D0_D1] = {Q_HALF, -Q_HALF};
        plan[REG_INITIAL_D2_D3] = {Q_MAX, Q_MIN};
        load_plan();
        push_word(S_MAX, 1'b0);
        push_word(S_MIN, 1'b0);
        push_word(24'sd0, 1'b0);
        push_word(-24'sd1, 1'b0);
        push_word(24'sd1, 1'b0);
        push_word(24'sd0, 1'b1);
        push_word(24'sd0, 1'b0);
        push_word(S_MAX, 1'b0);
        push_word(S_MIN, 1'b0);
        wait_drained();

        // Every coefficient and initial value at its most positive value.
        plan_fill(Q_MAX);
        load_plan();
        push_word(S_MAX, 1'b1);
        push_word(S_MIN, 1'b0);
        push_word(S_MAX, 1'b0);
        push_word(-24'sd1, 1'b0);
        wait_drained();

        // And at its most negative value.
        plan_fill(Q_MIN);
        load_plan();
        push_word(S_MIN, 1'b1);
        push_word(S_MAX, 1'b0);
        push_word(S_MIN, 1'b0);
        push_word(24'sd1, 1'b0);

        // Random phases, each with a fresh register set, stall pattern and gap mode.
        for (p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p % 5)
                1: begin
                    for (i = 0; i < NUM_REGS; i++) plan[i] = {corner_half(), corner_half()};
                    pct = 10;
                end
                3: begin
                    for (i = 0; i < NUM_REGS; i++) plan[i] = {$urandom, $urandom};
                    pct = 5;
                end
                default: begin
                    plan_stable();
                    pct = 3;
                end
            endcase
            load_plan();
            hold_phase = (p == 2 || p == 7);
            rx_mode = rx_mode_t'(p % 4);
            gaps_on = (p % 3 != 2) && !hold_phase;
            if (p == 4) begin
                // Sender pauses midway until the filter has handed back everything.
                queue_words(WORDS_PER_PHASE / 2, pct);
                wait_drained();
                queue_words(WORDS_PER_PHASE - WORDS_PER_PHASE / 2, pct);
            end else begin
                queue_words(WORDS_PER_PHASE, pct);
            end
            if (hold_phase) hold_req = 1'b1;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Run covered %0d filtered words over %0d register sets after reset,",
                 results_seen, settings_loaded);
        $display("with %0d delay restarts and %0d clipped outputs.", restarts_seen, clips_seen);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
